### rtl/skt_pkg.sv
// Shared types and sizes for the sorted key table.
// Used by skt_cell and sorted_key_table; depends on nothing else.
package skt_pkg;

   localparam int CAPACITY = 16;
   localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int CNT_W = $clog2(CAPACITY + 1);
   localparam int CMD_W = 2;
   localparam int ID_W = 32;
   localparam int KEY_W = 16;
   localparam int POS_W = 5;

   localparam logic [CMD_W-1:0] CMD_INSERT = 2'd0;
   localparam logic [CMD_W-1:0] CMD_SEARCH = 2'd1;
   localparam logic [CMD_W-1:0] CMD_REMOVE = 2'd2;

   typedef enum logic [1:0] {
      STATUS_OK      = 2'd0,
      STATUS_DUP     = 2'd1,
      STATUS_FULL    = 2'd2,
      STATUS_MISSING = 2'd3
   } status_type;

   typedef struct packed {
      logic [CMD_W-1:0] cmd;
      logic [ID_W-1:0]  entry_id;
      logic [KEY_W-1:0] entry_key;
   } req_type;

   typedef struct packed {
      status_type       status;
      logic [POS_W-1:0] position;
      logic [KEY_W-1:0] found_key;
      logic [POS_W-1:0] entry_count;
   } rsp_type;

   typedef struct packed {
      logic [ID_W-1:0]  id;
      logic [KEY_W-1:0] key;
   } entry_type;

   typedef enum logic [1:0] {
      LOAD_HOLD  = 2'd0,
      LOAD_NEW   = 2'd1,
      LOAD_LEFT  = 2'd2,
      LOAD_RIGHT = 2'd3
   } load_sel_type;

   typedef struct packed {
      logic         sample;
      entry_type    req_entry;
      load_sel_type load_sel;
   } cell_ctrl_type;

   typedef struct packed {
      logic match;
      logic key_ge;
      logic key_eq;
   } cell_flags_type;

endpackage

### rtl/skt_cell.sv
// One slot of the sorted key table: holds an entry, compares it against a request,
// and loads from itself, a new entry or either neighbor. Depends on skt_pkg.
module skt_cell (
   input  logic                    clock,
   input  skt_pkg::cell_ctrl_type  ctrl,
   input  logic                    live,
   input  skt_pkg::entry_type      left_entry,
   input  skt_pkg::entry_type      right_entry,
   output skt_pkg::entry_type      entry,
   output skt_pkg::cell_flags_type flags
);

   skt_pkg::entry_type      entry_ff;
   skt_pkg::cell_flags_type flags_ff;

   always_ff @(posedge clock) begin
      if (ctrl.sample) begin
         flags_ff.match  <= live && (entry_ff.id == ctrl.req_entry.id);
         flags_ff.key_ge <= entry_ff.key >= ctrl.req_entry.key;
         flags_ff.key_eq <= entry_ff.key == ctrl.req_entry.key;
      end
      unique case (ctrl.load_sel)
         skt_pkg::LOAD_HOLD:  entry_ff <= entry_ff;
         skt_pkg::LOAD_NEW:   entry_ff <= ctrl.req_entry;
         skt_pkg::LOAD_LEFT:  entry_ff <= left_entry;
         skt_pkg::LOAD_RIGHT: entry_ff <= right_entry;
         default:             entry_ff <= entry_ff;
      endcase
   end

   assign entry = entry_ff;
   assign flags = flags_ff;

endmodule

### rtl/sorted_key_table.sv
// Sorted key table: up to skt_pkg::CAPACITY entries (32-bit id, 16-bit key) kept in
// ascending key order in a row of cells. At the accept edge every cell compares its
// entry against the request and registers the result; in the update state the decision
// is committed, all cells shift or load in parallel and the response is registered. One
// request is in flight at a time, so a new request is taken only after the previous one
// has committed; a stalled response holds the commit. No clearing pass is needed after
// reset. Depends on skt_pkg and skt_cell.
module sorted_key_table (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  skt_pkg::req_type req_payload,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output skt_pkg::rsp_type rsp_payload
);

   typedef enum logic {
      ST_IDLE,
      ST_UPDATE
   } state_type;

   localparam int N = skt_pkg::CAPACITY;

   state_type                     state_ff, state_in;
   skt_pkg::req_type              op_ff;
   logic [skt_pkg::CNT_W-1:0]     count_ff, count_in;
   logic                          rsp_valid_ff;
   skt_pkg::rsp_type              rsp_payload_ff, rsp_in;

   skt_pkg::entry_type            op_entry;
   skt_pkg::entry_type            cell_entry [N];
   skt_pkg::entry_type            left_vec [N];
   skt_pkg::entry_type            right_vec [N];
   skt_pkg::cell_flags_type       cell_flags [N];
   skt_pkg::cell_ctrl_type        cell_ctrl [N];
   skt_pkg::load_sel_type         sel [N];

   logic [N-1:0] live, match, key_ge, key_eq, cond, first, pref;
   logic         accept, commit, any_match, full;
   logic [skt_pkg::KEY_W-1:0] hit_key;

   function automatic logic [skt_pkg::IDX_W-1:0] index_of(input logic [N-1:0] onehot);
      logic [skt_pkg::IDX_W-1:0] idx;
      idx = '0;
      for (int i = 0; i < N; i++) begin
         if (onehot[i]) begin
            idx = idx | skt_pkg::IDX_W'(i);
         end
      end
      return idx;
   endfunction

   assign accept = req_valid && !req_stall;
   assign req_stall = (state_ff != ST_IDLE);
   assign commit = (state_ff == ST_UPDATE) && (!rsp_valid_ff || !rsp_stall);
   assign full = (count_ff == skt_pkg::CNT_W'(N));

   // The request is compared in the accept cycle, so the cells see the port payload.
   always_comb begin
      op_entry.id  = op_ff.entry_id;
      op_entry.key = op_ff.entry_key;
      for (int i = 0; i < N; i++) begin
         live[i] = skt_pkg::CNT_W'(i) < count_ff;
         left_vec[i]  = (i == 0) ? op_entry : cell_entry[(i == 0) ? 0 : i - 1];
         right_vec[i] = (i == N - 1) ? cell_entry[i] : cell_entry[(i == N - 1) ? i : i + 1];
         cell_ctrl[i].sample              = accept;
         cell_ctrl[i].req_entry.id        = accept ? req_payload.entry_id : op_ff.entry_id;
         cell_ctrl[i].req_entry.key       = accept ? req_payload.entry_key : op_ff.entry_key;
         cell_ctrl[i].load_sel            = commit ? sel[i] : skt_pkg::LOAD_HOLD;
      end
   end

   genvar g;
   generate
      for (g = 0; g < N; g++) begin : g_cell
         skt_cell u_cell (
            .clock       (clock),
            .ctrl        (cell_ctrl[g]),
            .live        (live[g]),
            .left_entry  (left_vec[g]),
            .right_entry (right_vec[g]),
            .entry       (cell_entry[g]),
            .flags       (cell_flags[g])
         );
      end
   endgenerate

   // Keys are kept ascending, so the insert condition forms a thermometer and the
   // insert point is its lowest set bit. The head only yields to a strictly smaller key.
   always_comb begin
      hit_key = '0;
      for (int i = 0; i < N; i++) begin
         match[i]  = cell_flags[i].match;
         key_ge[i] = cell_flags[i].key_ge;
         key_eq[i] = cell_flags[i].key_eq;
         if (i == 0) begin
            cond[i] = !live[i] || (key_ge[i] && !key_eq[i]);
         end else begin
            cond[i] = !live[i] || key_ge[i];
         end
         if (match[i]) begin
            hit_key = hit_key | cell_entry[i].key;
         end
      end
      first = cond & ~(cond << 1);
      // Ids are unique, so match is one-hot or empty and this marks it and all above.
      pref = ~(match - N'(1));
      any_match = |match;
   end

   always_comb begin
      rsp_in.status      = skt_pkg::STATUS_OK;
      rsp_in.position    = '0;
      rsp_in.found_key   = '0;
      count_in           = count_ff;
      for (int i = 0; i < N; i++) begin
         sel[i] = skt_pkg::LOAD_HOLD;
      end
      unique case (op_ff.cmd)
         skt_pkg::CMD_INSERT: begin
            if (any_match) begin
               rsp_in.status = skt_pkg::STATUS_DUP;
            end else if (full) begin
               rsp_in.status = skt_pkg::STATUS_FULL;
            end else begin
               rsp_in.position = skt_pkg::POS_W'(index_of(first));
               count_in = count_ff + skt_pkg::CNT_W'(1);
               for (int i = 0; i < N; i++) begin
                  if (first[i]) begin
                     sel[i] = skt_pkg::LOAD_NEW;
                  end else if (i > 0 && cond[(i > 0) ? i - 1 : 0]) begin
                     sel[i] = skt_pkg::LOAD_LEFT;
                  end
               end
            end
         end
         skt_pkg::CMD_SEARCH, skt_pkg::CMD_REMOVE: begin
            if (!any_match) begin
               rsp_in.status = skt_pkg::STATUS_MISSING;
            end else begin
               rsp_in.position  = skt_pkg::POS_W'(index_of(match));
               rsp_in.found_key = hit_key;
               if (op_ff.cmd == skt_pkg::CMD_REMOVE) begin
                  count_in = count_ff - skt_pkg::CNT_W'(1);
                  for (int i = 0; i < N; i++) begin
                     if (pref[i]) begin
                        sel[i] = skt_pkg::LOAD_RIGHT;
                     end
                  end
               end
            end
         end
         default: begin
         end
      endcase
      rsp_in.entry_count = skt_pkg::POS_W'(count_in);
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE:   if (accept) state_in = ST_UPDATE;
         ST_UPDATE: if (commit) state_in = ST_IDLE;
         default:   state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (commit) begin
            count_ff     <= count_in;
            rsp_valid_ff <= 1'b1;
         end else if (rsp_valid_ff && !rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
      if (accept) begin
         op_ff <= req_payload;
      end
      if (commit) begin
         rsp_payload_ff <= rsp_in;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_payload_ff;

endmodule

### dv/tb_sorted_key_table.sv
`timescale 1ns / 100ps
// Self-checking testbench for sorted_key_table: a directed table, then random table traffic.
// Results are checked against a behavioral copy of the table kept here; uses skt_pkg types.
module tb_sorted_key_table;

   localparam logic [skt_pkg::CMD_W-1:0] CMD_UNUSED = 2'd3;
   localparam int RANDOM_ITEMS = 1300;
   localparam int CYCLE_LIMIT = 400000;
   localparam int DRAIN_CYCLES = 20;

   typedef struct {
      skt_pkg::req_type req;
      bit               typed;
      skt_pkg::rsp_type rsp;
   } stim_row_type;

   logic             clock = 1'b0;
   logic             reset;
   logic             req_valid;
   logic             req_stall;
   skt_pkg::req_type req_payload;
   logic             rsp_valid;
   logic             rsp_stall;
   skt_pkg::rsp_type rsp_payload;

   // Behavioral copy of the table contents.
   logic [skt_pkg::ID_W-1:0]  table_ids [skt_pkg::CAPACITY];
   logic [skt_pkg::KEY_W-1:0] table_keys [skt_pkg::CAPACITY];
   int                        table_fill = 0;

   skt_pkg::rsp_type expected_rsps [$];
   stim_row_type     directed_rows [$];
   int               error_count = 0;
   int               cycle_count = 0;
   int               rsp_wait = 0;
   bit               quiet_stretch = 1'b0;

   sorted_key_table dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("[FAIL] regression broken");
         $finish;
      end
   end

   // Applies one request to the table copy and returns the response it should produce.
   function automatic skt_pkg::rsp_type apply_table_op(input skt_pkg::req_type r);
      skt_pkg::rsp_type o;
      int               at;
      int               slot;
      o = '0;
      o.status = skt_pkg::STATUS_OK;
      at = table_fill;
      for (int i = 0; i < table_fill; i++) begin
         if (table_ids[i] == r.entry_id) begin
            at = i;
            break;
         end
      end
      if (r.cmd == skt_pkg::CMD_INSERT) begin
         if (at < table_fill) begin
            o.status = skt_pkg::STATUS_DUP;
         end else if (table_fill >= skt_pkg::CAPACITY) begin
            o.status = skt_pkg::STATUS_FULL;
         end else begin
            // The head is passed over on an equal key; later entries are not.
            slot = table_fill;
            if (table_fill == 0 || table_keys[0] > r.entry_key) begin
               slot = 0;
            end else begin
               for (int i = 1; i < table_fill; i++) begin
                  if (table_keys[i] >= r.entry_key) begin
                     slot = i;
                     break;
                  end
               end
            end
            for (int i = table_fill; i > slot; i--) begin
               table_ids[i] = table_ids[i-1];
               table_keys[i] = table_keys[i-1];
            end
            table_ids[slot] = r.entry_id;
            table_keys[slot] = r.entry_key;
            table_fill++;
            o.position = skt_pkg::POS_W'(slot);
         end
      end else if (r.cmd == skt_pkg::CMD_SEARCH || r.cmd == skt_pkg::CMD_REMOVE) begin
         if (at >= table_fill) begin
            o.status = skt_pkg::STATUS_MISSING;
         end else begin
            o.position = skt_pkg::POS_W'(at);
            o.found_key = table_keys[at];
            if (r.cmd == skt_pkg::CMD_REMOVE) begin
               for (int i = at; i + 1 < table_fill; i++) begin
                  table_ids[i] = table_ids[i+1];
                  table_keys[i] = table_keys[i+1];
               end
               table_fill--;
            end
         end
      end
      o.entry_count = skt_pkg::POS_W'(table_fill);
      return o;
   endfunction

   function automatic stim_row_type make_row(input logic [skt_pkg::CMD_W-1:0] cmd,
                                             input logic [skt_pkg::ID_W-1:0] id,
                                             input logic [skt_pkg::KEY_W-1:0] key,
                                             input bit typed,
                                             input skt_pkg::status_type status,
                                             input int pos,
                                             input logic [skt_pkg::KEY_W-1:0] fkey,
                                             input int count);
      stim_row_type row;
      row.req.cmd = cmd;
      row.req.entry_id = id;
      row.req.entry_key = key;
      row.typed = typed;
      row.rsp.status = status;
      row.rsp.position = skt_pkg::POS_W'(pos);
      row.rsp.found_key = fkey;
      row.rsp.entry_count = skt_pkg::POS_W'(count);
      return row;
   endfunction

   // Mode 0 grows the table, mode 1 drains it, mode 2 lies between the two.
   function automatic skt_pkg::req_type random_request(input int mode);
      skt_pkg::req_type r;
      int unsigned      pick;
      int unsigned      insert_share;
      insert_share = (mode == 0) ? 70 : (mode == 1) ? 20 : 45;
      r.entry_id = $urandom;
      r.entry_key = ($urandom_range(0, 3) == 0) ? skt_pkg::KEY_W'($urandom)
                                                : skt_pkg::KEY_W'($urandom_range(0, 15));
      pick = $urandom_range(0, 99);
      if (pick < 4) begin
         r.cmd = CMD_UNUSED;
      end else if (pick < 4 + insert_share) begin
         r.cmd = skt_pkg::CMD_INSERT;
         if (table_fill > 0 && $urandom_range(0, 99) < 15)
            r.entry_id = table_ids[$urandom_range(0, table_fill - 1)];
      end else begin
         r.cmd = ($urandom_range(0, 4) < 2) ? skt_pkg::CMD_SEARCH : skt_pkg::CMD_REMOVE;
         if (table_fill > 0 && $urandom_range(0, 99) < 85)
            r.entry_id = table_ids[$urandom_range(0, table_fill - 1)];
      end
      return r;
   endfunction

   task automatic send_request(input skt_pkg::req_type r, input bit typed,
                               input skt_pkg::rsp_type typed_rsp);
      skt_pkg::rsp_type predicted;
      int               gap;
      gap = quiet_stretch ? 0 : $urandom_range(0, 10);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_payload <= r;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      predicted = apply_table_op(r);
      expected_rsps.push_back(typed ? typed_rsp : predicted);
   endtask

   task automatic wait_for_drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (expected_rsps.size() != 0) @(posedge clock);
   endtask

   // Response checker and response-side stall generator.
   always @(posedge clock) begin
      skt_pkg::rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_rsps.size() == 0) begin
            $display("%0t: unexpected response, expected none, got %h", $time, rsp_payload);
            error_count++;
         end else begin
            want = expected_rsps.pop_front();
            if (rsp_payload.status !== want.status) begin
               $display("%0t: status mismatch, expected %0d, got %0d",
                        $time, want.status, rsp_payload.status);
               error_count++;
            end
            if (rsp_payload.position !== want.position) begin
               $display("%0t: position mismatch, expected %0d, got %0d",
                        $time, want.position, rsp_payload.position);
               error_count++;
            end
            if (rsp_payload.found_key !== want.found_key) begin
               $display("%0t: found_key mismatch, expected %h, got %h",
                        $time, want.found_key, rsp_payload.found_key);
               error_count++;
            end
            if (rsp_payload.entry_count !== want.entry_count) begin
               $display("%0t: entry_count mismatch, expected %0d, got %0d",
                        $time, want.entry_count, rsp_payload.entry_count);
               error_count++;
            end
         end
         rsp_wait = quiet_stretch ? 0 : $urandom_range(0, 10);
      end
      if (rsp_wait > 0) begin
         rsp_stall <= 1'b1;
         rsp_wait--;
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   initial begin
      int mode;
      reset <= 1'b1;
      req_valid <= 1'b0;
      req_payload <= '0;

      // Empty table, extreme ids and keys, duplicates, the unused command, then a full table.
      directed_rows.push_back(make_row(skt_pkg::CMD_SEARCH, 32'h0000_0000, 16'h0000, 1,
                                       skt_pkg::STATUS_MISSING, 0, 16'h0000, 0));
      directed_rows.push_back(make_row(skt_pkg::CMD_REMOVE, 32'hFFFF_FFFF, 16'hFFFF, 1,
                                       skt_pkg::STATUS_MISSING, 0, 16'h0000, 0));
      directed_rows.push_back(make_row(CMD_UNUSED, 32'hFFFF_FFFF, 16'hFFFF, 1,
                                       skt_pkg::STATUS_OK, 0, 16'h0000, 0));
      directed_rows.push_back(make_row(skt_pkg::CMD_INSERT, 32'hFFFF_FFFF, 16'hFFFF, 1,
                                       skt_pkg::STATUS_OK, 0, 16'h0000, 1));
      directed_rows.push_back(make_row(skt_pkg::CMD_INSERT, 32'hFFFF_FFFF, 16'h0000, 1,
                                       skt_pkg::STATUS_DUP, 0, 16'h0000, 1));
      directed_rows.push_back(make_row(skt_pkg::CMD_INSERT, 32'h0000_0000, 16'h0000, 1,
                                       skt_pkg::STATUS_OK, 0, 16'h0000, 2));
      directed_rows.push_back(make_row(skt_pkg::CMD_INSERT, 32'h0000_0001, 16'h0000, 0,
                                       skt_pkg::STATUS_OK, 0, 16'h0000, 0));
      directed_rows.push_back(make_row(skt_pkg::CMD_SEARCH, 32'hFFFF_FFFF, 16'h1234, 1,
                                       skt_pkg::STATUS_OK, 2, 16'hFFFF, 3));
      for (int i = 0; i < skt_pkg::CAPACITY - 3; i++) begin
         directed_rows.push_back(make_row(skt_pkg::CMD_INSERT, 32'h5A00_0000 + i,
                                          (i == skt_pkg::CAPACITY - 4) ? 16'hFFFF :
                                          (i % 3 == 0) ? 16'h0000 :
                                          skt_pkg::KEY_W'(i * 5003),
                                          0, skt_pkg::STATUS_OK, 0, 16'h0000, 0));
      end
      directed_rows.push_back(make_row(skt_pkg::CMD_INSERT, 32'hA5A5_A5A5, 16'h0007, 1,
                                       skt_pkg::STATUS_FULL, 0, 16'h0000,
                                       skt_pkg::CAPACITY));
      directed_rows.push_back(make_row(skt_pkg::CMD_INSERT, 32'h0000_0000, 16'h0001, 1,
                                       skt_pkg::STATUS_DUP, 0, 16'h0000,
                                       skt_pkg::CAPACITY));
      directed_rows.push_back(make_row(skt_pkg::CMD_REMOVE, 32'h0000_0000, 16'h0000, 1,
                                       skt_pkg::STATUS_OK, 0, 16'h0000,
                                       skt_pkg::CAPACITY - 1));
      directed_rows.push_back(make_row(skt_pkg::CMD_REMOVE, 32'hFFFF_FFFF, 16'h0000, 0,
                                       skt_pkg::STATUS_OK, 0, 16'h0000, 0));

      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (directed_rows[i])
         send_request(directed_rows[i].req, directed_rows[i].typed, directed_rows[i].rsp);

      mode = 0;
      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         if (n % 48 == 0)
            mode = $urandom_range(0, 2);
         if (n % 100 == 0)
            quiet_stretch = ($urandom_range(0, 3) == 0);
         if (n == RANDOM_ITEMS / 2 || $urandom_range(0, 199) == 0)
            wait_for_drain();
         send_request(random_request(mode), 1'b0, '0);
      end
      req_valid <= 1'b0;

      while (expected_rsps.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (error_count == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule
